// File: rtl/core/opl_pkg.sv
// Shared codes, command type and sizing constants for the ordered point list.
package opl_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_COORD_BITS = 32;

   // cell position compare width, covers the largest supported capacity
   localparam int POS_BITS = 11;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_MODIFY = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_INSERT = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // per-cycle action broadcast to every cell
   localparam logic [2:0] ACT_HOLD  = 3'd0;
   localparam logic [2:0] ACT_WRITE = 3'd1;
   localparam logic [2:0] ACT_CLOSE = 3'd2;
   localparam logic [2:0] ACT_OPEN  = 3'd3;
   localparam logic [2:0] ACT_SNAP  = 3'd4;
   localparam logic [2:0] ACT_SLIDE = 3'd5;

   typedef struct packed {
      logic [2:0]          act;
      logic [POS_BITS-1:0] pos;
   } opl_cmd_type;

endpackage

// File: rtl/core/opl_cell.sv
// One list cell: holds one entry and one read tap, trades with its neighbors.
module opl_cell #(
   parameter int IDX     = 0,
   parameter int ENTRY_W = 64
) (
   input  logic                 clock,
   input  opl_pkg::opl_cmd_type cmd,
   input  logic [ENTRY_W-1:0]   point,
   input  logic [ENTRY_W-1:0]   left_entry,
   input  logic [ENTRY_W-1:0]   right_entry,
   input  logic [ENTRY_W-1:0]   right_tap,
   output logic [ENTRY_W-1:0]   entry,
   output logic [ENTRY_W-1:0]   tap
);
   import opl_pkg::*;

   localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(IDX);

   logic               hit;
   logic               above;
   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] tap_ff;

   assign hit   = (cmd.pos == MY_POS);
   assign above = (MY_POS > cmd.pos);

   always_ff @(posedge clock) begin
      case (cmd.act)
         ACT_WRITE: begin
            if (hit) entry_ff <= point;
         end
         ACT_CLOSE: begin
            if (hit || above) entry_ff <= right_entry;
         end
         ACT_OPEN: begin
            if (hit) entry_ff <= point;
            else if (above) entry_ff <= left_entry;
         end
         ACT_SNAP: begin
            tap_ff <= entry_ff;
         end
         ACT_SLIDE: begin
            tap_ff <= right_tap;
         end
         default: begin
         end
      endcase
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule

// File: rtl/core/ordered_point_list_insert_delete_unit.sv
// Top level of the ordered point list: control, count and the row of cells.
//
// Usage: drive req_opcode, req_index, req_point_x and req_point_y with start
// high; the beat is taken at a rising edge where busy is low. Every taken beat
// yields exactly one response beat, shown for one cycle with rsp_valid high;
// the receiver must take it then, it cannot stall the block.
// Append, modify, delete, insert, clear and failed reads respond in the cycle
// after the accepting edge and busy stays low, so one such beat per clock is
// sustained. Insert and delete shift every cell at or above the index at once.
// A valid read snapshots all cells into a tap chain, then slides it toward
// cell 0 one cell per cycle until the indexed entry reaches cell 0; busy is
// high meanwhile and drops as the response is shown.
// Reset (synchronous, active high) empties the list and drops busy and
// rsp_valid; stored entries are not cleared and never read before written.
// Coordinates keep their low COORD_BITS bits and read back sign-extended.
module ordered_point_list_insert_delete_unit #(
   parameter int CAPACITY   = opl_pkg::DEF_CAPACITY,
   parameter int COORD_BITS = opl_pkg::DEF_COORD_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic [5:0]         req_index,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_x,
   output logic signed [31:0] rsp_read_y,
   output logic [6:0]         rsp_entry_count,
   output logic [1:0]         rsp_status
);
   import opl_pkg::*;

   localparam int ENTRY_W = 2 * COORD_BITS;
   localparam int CNT_W   = $clog2(CAPACITY + 1);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_READ = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [5:0]          left_ff, left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_x_ff, rsp_x_in;
   logic signed [31:0]  rsp_y_ff, rsp_y_in;
   logic [6:0]          rsp_count_ff;
   logic [1:0]          rsp_status_ff, status_in;

   opl_cmd_type         cmd;
   logic                accept;
   logic                rd_go;
   logic                rd_done;
   logic                full;
   logic                in_range;
   logic [POS_BITS-1:0] idx_ext;
   logic [POS_BITS-1:0] cnt_ext;
   logic [ENTRY_W-1:0]  point;
   logic signed [COORD_BITS-1:0] tap_x;
   logic signed [COORD_BITS-1:0] tap_y;

   logic [ENTRY_W-1:0]  ent [CAPACITY];
   logic [ENTRY_W-1:0]  tap [CAPACITY];

   assign accept   = start && !busy;
   assign idx_ext  = POS_BITS'(req_index);
   assign cnt_ext  = POS_BITS'(count_ff);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign in_range = (idx_ext < cnt_ext);
   assign point    = {req_point_y[COORD_BITS-1:0], req_point_x[COORD_BITS-1:0]};
   assign rd_done  = (state_ff == STATE_READ) && (left_ff == '0);
   assign tap_x    = tap[0][COORD_BITS-1:0];
   assign tap_y    = tap[0][ENTRY_W-1:COORD_BITS];

   always_comb begin
      cmd.act   = ACT_HOLD;
      cmd.pos   = idx_ext;
      count_in  = count_ff;
      status_in = ST_DONE;
      rd_go     = 1'b0;
      if (accept) begin
         case (req_opcode)
            OP_APPEND: begin
               if (!full) begin
                  cmd.act  = ACT_WRITE;
                  cmd.pos  = cnt_ext;
                  count_in = count_ff + 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end
            OP_READ: begin
               if (in_range) begin
                  cmd.act = ACT_SNAP;
                  rd_go   = 1'b1;
               end else begin
                  status_in = ST_RANGE;
               end
            end
            OP_MODIFY: begin
               if (in_range) cmd.act = ACT_WRITE;
               else status_in = ST_RANGE;
            end
            OP_DELETE: begin
               if (in_range) begin
                  cmd.act  = ACT_CLOSE;
                  count_in = count_ff - 1'b1;
               end else begin
                  status_in = ST_RANGE;
               end
            end
            OP_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else if (in_range) begin
                  cmd.act  = ACT_OPEN;
                  count_in = count_ff + 1'b1;
               end else begin
                  status_in = ST_RANGE;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (state_ff == STATE_READ && !rd_done) begin
         cmd.act = ACT_SLIDE;
      end
   end

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      if (rd_go) begin
         state_in = STATE_READ;
         left_in  = req_index;
      end else if (rd_done) begin
         state_in = STATE_IDLE;
      end else if (state_ff == STATE_READ) begin
         left_in = left_ff - 1'b1;
      end
   end

   assign rsp_valid_in = (accept && !rd_go) || rd_done;
   assign rsp_x_in     = rd_done ? 32'(tap_x) : '0;
   assign rsp_y_in     = rd_done ? 32'(tap_y) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      if (rsp_valid_in) begin
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_count_ff  <= 7'(count_in);
         rsp_status_ff <= status_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ENTRY_W-1:0] left_entry;
      logic [ENTRY_W-1:0] right_entry;
      logic [ENTRY_W-1:0] right_tap;

      if (i == 0) begin : g_head
         assign left_entry = '0;
      end else begin : g_mid_l
         assign left_entry = ent[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = ent[i];
         assign right_tap   = '0;
      end else begin : g_mid_r
         assign right_entry = ent[i+1];
         assign right_tap   = tap[i+1];
      end

      opl_cell #(
         .IDX     (i),
         .ENTRY_W (ENTRY_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .point       (point),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .right_tap   (right_tap),
         .entry       (ent[i]),
         .tap         (tap[i])
      );
   end

   assign busy            = (state_ff == STATE_READ);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_x      = rsp_x_ff;
   assign rsp_read_y      = rsp_y_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   // a read in flight never overlaps a response beat
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response beat while read in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && !rd_go) |=> rsp_valid)
      else $error("single-cycle op gave no response");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_read_x == '0 && rsp_read_y == '0))
      else $error("failed op returned nonzero coordinates");

   a_read_hold_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_READ) |=> $stable(count_ff))
      else $error("count changed during read");

endmodule
